FILE: design/button_debounce_long_press_macros.svh
// ----------------------------------------------------------------------------
// button_debounce_long_press_macros.svh
// assertion shorthands used by the checker file
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define BDLP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdlp assertion failed");

// next-cycle implication, disabled while reset is high
`define BDLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdlp assertion failed");

`endif

FILE: design/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// bdlp_pkg
// shared types and constants of the button debounce / long press block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdlp_pkg;

   localparam int PORT_BITS   = 6;   // buttons visible on the ports
   localparam int CODE_W      = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;
   localparam int DEB_TICK_W  = 8;
   localparam int HOLD_W      = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE_MS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS_MS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_ENABLE   = 2'd2;

   // time limits and defaults in ms, and the default long enable mask
   localparam logic [CSR_DATA_W-1:0] DEB_MS_MAX      = 16'd1000;
   localparam logic [CSR_DATA_W-1:0] DEB_MS_DEFAULT  = 16'd30;
   localparam logic [CSR_DATA_W-1:0] LONG_MS_MIN     = 16'd200;
   localparam logic [CSR_DATA_W-1:0] LONG_MS_MAX     = 16'd30000;
   localparam logic [CSR_DATA_W-1:0] LONG_MS_DEFAULT = 16'd3000;
   localparam logic [PORT_BITS-1:0]  LONG_EN_DEFAULT = 6'd39;

   localparam logic [DEB_TICK_W-1:0] DEB_COUNT_MAX = 8'hFF;
   localparam logic [HOLD_W-1:0]     HOLD_MAX      = 16'hFFFF;

   typedef struct packed {
      logic [DEB_TICK_W-1:0] settle_ticks;
      logic [HOLD_W-1:0]     hold_limit;
      logic [PORT_BITS-1:0]  long_en;
   } bdlp_cfg_type;

   typedef struct packed {
      logic pressed;
      logic long_held;
      logic short_ev;
      logic long_ev;
   } bdlp_lane_stat_type;

   // first member sits in the top bits
   typedef struct packed {
      logic [PORT_BITS-1:0] long_held_mask;
      logic [PORT_BITS-1:0] pressed_mask;
      logic [CODE_W-1:0]    event_code;
   } bdlp_rsp_type;

endpackage

FILE: design/bdlp_lane.sv
// ----------------------------------------------------------------------------
// bdlp_lane
// debounce, hold counter and event detection for one button
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdlp_lane
   import bdlp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               step_en,
   input  logic               raw,
   input  logic               long_en,
   input  logic [DEB_TICK_W-1:0] settle_ticks,
   input  logic [HOLD_W-1:0]  hold_limit,
   output bdlp_lane_stat_type stat
);

   logic [DEB_TICK_W-1:0] debounce_count_ff, debounce_count_in, dc_next;
   logic [HOLD_W-1:0]     hold_count_ff, hold_count_in, hc_next;
   logic                  is_pressed_ff, is_pressed_in;
   logic                  long_done_ff, long_done_in;
   logic                  fire;

   always_comb begin
      dc_next = debounce_count_ff;
      if ((debounce_count_ff != DEB_COUNT_MAX) && (debounce_count_ff < settle_ticks)) begin
         dc_next = debounce_count_ff + 1'b1;
      end
      hc_next = (hold_count_ff != HOLD_MAX) ? hold_count_ff + 1'b1 : hold_count_ff;
      fire    = (hc_next == hold_limit) && !long_done_ff && long_en;

      debounce_count_in = debounce_count_ff;
      hold_count_in     = hold_count_ff;
      is_pressed_in     = is_pressed_ff;
      long_done_in      = long_done_ff;
      stat              = '0;

      if (raw) begin
         debounce_count_in = dc_next;
         if (dc_next >= settle_ticks) begin
            is_pressed_in  = 1'b1;
            hold_count_in  = hc_next;
            stat.pressed   = 1'b1;
            stat.long_held = long_done_ff || (hc_next >= hold_limit);
            stat.long_ev   = fire;
            if (fire) begin
               long_done_in = 1'b1;
            end
         end
      end else begin
         // release is immediate, no debounce
         if (is_pressed_ff) begin
            stat.short_ev = !long_done_ff;
            is_pressed_in = 1'b0;
            hold_count_in = '0;
            long_done_in  = 1'b0;
         end
         debounce_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_count_ff <= '0;
         hold_count_ff     <= '0;
         is_pressed_ff     <= 1'b0;
         long_done_ff      <= 1'b0;
      end else if (step_en) begin
         debounce_count_ff <= debounce_count_in;
         hold_count_ff     <= hold_count_in;
         is_pressed_ff     <= is_pressed_in;
         long_done_ff      <= long_done_in;
      end
   end

endmodule

FILE: design/bdlp_merge.sv
// ----------------------------------------------------------------------------
// bdlp_merge
// picks the lowest-numbered event and gathers the button masks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdlp_merge
   import bdlp_pkg::*;
#(
   parameter int NUM_BUTTONS = 6
)(
   input  bdlp_lane_stat_type stat [NUM_BUTTONS],
   output bdlp_rsp_type       rsp
);

   logic [CODE_W-1:0]    code;
   logic [PORT_BITS-1:0] pr_mask, lh_mask;

   // walk from the top so the lowest button wins
   always_comb begin
      code = '0;
      for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
         if (stat[i].short_ev) begin
            code = CODE_W'(i + 1);
         end else if (stat[i].long_ev) begin
            code = CODE_W'(NUM_BUTTONS + 1 + i);
         end
      end
   end

   for (genvar g = 0; g < PORT_BITS; g++) begin : g_mask
      if (g < NUM_BUTTONS) begin : g_on
         assign pr_mask[g] = stat[g].pressed;
         assign lh_mask[g] = stat[g].long_held;
      end else begin : g_off
         assign pr_mask[g] = 1'b0;
         assign lh_mask[g] = 1'b0;
      end
   end

   assign rsp.event_code     = code;
   assign rsp.pressed_mask   = pr_mask;
   assign rsp.long_held_mask = lh_mask;

endmodule

FILE: design/bdlp_cfg.sv
// ----------------------------------------------------------------------------
// bdlp_cfg
// register file: invalid times take defaults; converts to scan ticks on write
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdlp_cfg
   import bdlp_pkg::*;
#(
   parameter int SCAN_PERIOD_MS = 10
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [CSR_IDX_W-1:0]  wr_index,
   input  logic [CSR_DATA_W-1:0] wr_data,
   output bdlp_cfg_type          cfg
);

   // ms / period as a multiply by a rounded-up reciprocal, exact for 16-bit ms
   localparam int SHIFT   = CSR_DATA_W + $clog2(SCAN_PERIOD_MS);
   localparam int RECIP   = ((1 << SHIFT) + SCAN_PERIOD_MS - 1) / SCAN_PERIOD_MS;
   localparam int RECIP_W = CSR_DATA_W + 2;
   localparam int PROD_W  = CSR_DATA_W + RECIP_W;
   localparam int DEB_RST_Q  = int'(DEB_MS_DEFAULT) / SCAN_PERIOD_MS;
   localparam int LONG_RST_Q = int'(LONG_MS_DEFAULT) / SCAN_PERIOD_MS;
   localparam int DEB_RST    = (DEB_RST_Q == 0) ? 1 : DEB_RST_Q;
   localparam int LONG_RST   = (LONG_RST_Q == 0) ? 1 : LONG_RST_Q;

   logic [CSR_DATA_W-1:0] deb_ms, long_ms, ms_sel;
   logic [PROD_W-1:0]     prod, prod_sh;
   logic [HOLD_W-1:0]     ticks;
   logic [DEB_TICK_W-1:0] settle_ticks_ff, settle_ticks_in;
   logic [HOLD_W-1:0]     hold_limit_ff, hold_limit_in;
   logic [PORT_BITS-1:0]  long_en_ff, long_en_in;

   always_comb begin
      deb_ms  = ((wr_data == '0) || (wr_data > DEB_MS_MAX)) ? DEB_MS_DEFAULT : wr_data;
      long_ms = ((wr_data < LONG_MS_MIN) || (wr_data > LONG_MS_MAX)) ?
                LONG_MS_DEFAULT : wr_data;
      ms_sel  = (wr_index == CSR_DEBOUNCE_MS) ? deb_ms : long_ms;
      prod    = PROD_W'(ms_sel) * PROD_W'(RECIP_W'(RECIP));
      prod_sh = prod >> SHIFT;
      ticks   = (prod_sh[HOLD_W-1:0] == '0) ? HOLD_W'(1) : prod_sh[HOLD_W-1:0];

      settle_ticks_in = settle_ticks_ff;
      hold_limit_in   = hold_limit_ff;
      long_en_in      = long_en_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_DEBOUNCE_MS:   settle_ticks_in = ticks[DEB_TICK_W-1:0];
            CSR_LONG_PRESS_MS: hold_limit_in   = ticks;
            CSR_LONG_ENABLE:   long_en_in      = wr_data[PORT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ticks_ff <= DEB_TICK_W'(DEB_RST);
         hold_limit_ff   <= HOLD_W'(LONG_RST);
         long_en_ff      <= LONG_EN_DEFAULT;
      end else begin
         settle_ticks_ff <= settle_ticks_in;
         hold_limit_ff   <= hold_limit_in;
         long_en_ff      <= long_en_in;
      end
   end

   assign cfg.settle_ticks = settle_ticks_ff;
   assign cfg.hold_limit   = hold_limit_ff;
   assign cfg.long_en      = long_en_ff;

endmodule

FILE: design/bdlp_skid.sv
// ----------------------------------------------------------------------------
// bdlp_skid
// output register with a skid entry so input and output stall independently
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdlp_skid
   import bdlp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  bdlp_rsp_type in_data,
   output logic         out_valid,
   input  logic         out_ready,
   output bdlp_rsp_type out_data
);

   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   bdlp_rsp_type out_data_ff, out_data_in;
   bdlp_rsp_type skid_data_ff, skid_data_in;
   logic         in_fire, out_fire;

   assign in_ready = !skid_valid_ff;
   assign in_fire  = in_valid && in_ready;
   assign out_fire = out_valid_ff && out_ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_data_in   = out_data_ff;
      skid_data_in  = skid_data_ff;
      if (out_fire) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (in_fire) begin
            out_data_in = in_data;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (in_fire) begin
         if (!out_valid_ff) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

FILE: design/button_debounce_long_press.sv
// ----------------------------------------------------------------------------
// button_debounce_long_press
// six-button debouncer with short and long press events
// ----------------------------------------------------------------------------
// usage:
//   req_ carries one beat per scan tick with the raw button levels; every
//   request beat produces exactly one rsp_ beat with the event code and the
//   pressed and long-held masks for that tick
//   csr_ writes debounce time, long-press time (both in ms) and the long
//   event enable mask; out-of-range times take the defaults and turn into
//   ticks as written, so a tick may follow the write in the very next cycle
// throughput and output register:
//   one beat per cycle sustained while rsp_tready is high; the result is
//   registered in the output register behind the lane logic
// reset:
//   all button state clears, registers return to 30 ms / 3000 ms / mask 39,
//   no result is pending and req_tready is high
// stalls:
//   a two-entry output stage holds results while rsp_tready is low; the
//   block takes one more request beat and then drops req_tready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_debounce_long_press
   import bdlp_pkg::*;
#(
   parameter int NUM_BUTTONS    = 6,
   parameter int SCAN_PERIOD_MS = 10
)(
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [5:0] raw_pressed, [7:6] zero
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [3:0] event_code, [9:4] pressed_mask,
                                    // [15:10] long_held_mask
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   bdlp_cfg_type       cfg;
   bdlp_lane_stat_type lane_stat [NUM_BUTTONS];
   bdlp_rsp_type       merged, rsp_out;
   logic               req_fire;

   // registers never stall
   assign csr_ready = 1'b1;

   // a lane steps only on an accepted request beat
   assign req_fire = req_tvalid && req_tready;

   bdlp_cfg #(
      .SCAN_PERIOD_MS(SCAN_PERIOD_MS)
   ) u_cfg (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (csr_valid && csr_ready),
      .wr_index(csr_index),
      .wr_data (csr_data),
      .cfg     (cfg)
   );

   // one lane per button; lanes past the port width see no press
   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
      logic lane_raw, lane_en;
      if (g < PORT_BITS) begin : g_port
         assign lane_raw = req_tdata[g];
         assign lane_en  = cfg.long_en[g];
      end else begin : g_none
         assign lane_raw = 1'b0;
         assign lane_en  = 1'b0;
      end

      bdlp_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .step_en     (req_fire),
         .raw         (lane_raw),
         .long_en     (lane_en),
         .settle_ticks(cfg.settle_ticks),
         .hold_limit  (cfg.hold_limit),
         .stat        (lane_stat[g])
      );
   end

   // lowest button event wins, masks gathered from all lanes
   bdlp_merge #(
      .NUM_BUTTONS(NUM_BUTTONS)
   ) u_merge (
      .stat(lane_stat),
      .rsp (merged)
   );

   bdlp_skid u_skid (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_data  (merged),
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_data (rsp_out)
   );

   assign rsp_tdata = {rsp_out.long_held_mask, rsp_out.pressed_mask, rsp_out.event_code};

endmodule

FILE: design/bdlp_checker.sv
// ----------------------------------------------------------------------------
// bdlp_checker
// port-level checks of the debounce block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "button_debounce_long_press_macros.svh"

module bdlp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   logic req_fire, rsp_stall, stray_long;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign stray_long = |(rsp_tdata[15:10] & ~rsp_tdata[9:4]);

   // a stalled result beat holds
   `BDLP_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))

   // long-held buttons are always pressed
   `BDLP_ASSERT_NOW(a_long_in_pressed, clock, reset, rsp_tvalid, !stray_long)

   // nothing pending and ready right after reset
   `BDLP_ASSERT_NOW(a_reset_clear, clock, reset, $fell(reset), !rsp_tvalid && req_tready)

   // a result only shows up after a request beat
   `BDLP_ASSERT_NEXT(a_no_invented, clock, reset, !rsp_tvalid, !rsp_tvalid || $past(req_fire))

endmodule

bind button_debounce_long_press bdlp_checker u_bdlp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);
